### sv/crs_pkg.sv
// shared types, widths and helpers for the catmull-rom curve sampler
// no dependencies; imported by every module of the block
`default_nettype none

package crs_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 12;

  // parameter step limits, Q0.FRAC_BITS
  localparam int STEP_W     = FRAC_BITS + 1;
  localparam int ONE_SEG    = 1 << FRAC_BITS;
  localparam int STEP_MIN   = (ONE_SEG + 62) / 63;
  localparam int STEP_RESET = 410;

  // blend weights stay within 2 * 2^FRAC_BITS in magnitude
  localparam int WGT_W = FRAC_BITS + 4;
  // shared multiplier operand and accumulator widths
  localparam int MUL_W = WGT_W + 1;
  localparam int ACC_W = 32;

  // vertex output range
  localparam int OUT_W   = 14;
  localparam int OUT_MIN = -4096;
  localparam int OUT_MAX = 8191;

  localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0]         coord_t;
  typedef logic signed [WGT_W-1:0]       wgt_t;
  typedef logic signed [MUL_W-1:0]       mul_op_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [OUT_W-1:0]       vout_t;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  typedef struct packed {
    logic  load;
    vout_t x;
    vout_t y;
    logic  last;
  } vtx_t;

  // divide by 2^(FRAC_BITS+1) toward zero, then clamp to the output range
  function automatic vout_t scale_sat(input acc_t s);
    acc_t q;
    q = s >>> (FRAC_BITS + 1);
    if (s[ACC_W-1] && (|s[FRAC_BITS:0])) begin
      q = q + acc_t'(1);
    end
    if (q < acc_t'(OUT_MIN)) begin
      q = acc_t'(OUT_MIN);
    end else if (q > acc_t'(OUT_MAX)) begin
      q = acc_t'(OUT_MAX);
    end
    return q[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/crs_mac.sv
// shared signed multiply-accumulate unit of the curve sampler
// depends on crs_pkg for operand and accumulator widths
`default_nettype none

module crs_mac (
  input  wire logic              clk,
  input  wire crs_pkg::mac_ctl_t ctl_i,
  input  wire crs_pkg::mul_op_t  a_i,
  input  wire crs_pkg::mul_op_t  b_i,
  output crs_pkg::acc_t          acc_o
);
  import crs_pkg::*;

  logic signed [2*MUL_W-1:0] prod;
  acc_t                      acc_r;
  acc_t                      acc_nxt;

  assign prod = a_i * b_i;

  always_comb begin
    if (ctl_i.clr) begin
      acc_nxt = ACC_W'(prod);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_o = acc_r;

endmodule

`default_nettype wire

### sv/crs_seq.sv
// sequencer of the curve sampler: point window, sample parameter and the
// per-vertex schedule on the shared mac; depends on crs_pkg and crs_mac
`default_nettype none

module crs_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire crs_pkg::coord_t           px_i,
  input  wire crs_pkg::coord_t           py_i,
  input  wire logic                      last_i,
  input  wire logic [crs_pkg::STEP_W-1:0] step_i,
  input  wire logic                      slot_free_i,
  output crs_pkg::vtx_t                  vtx_o
);
  import crs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_CUBE = 3'd2;
  localparam logic [2:0] S_WGT  = 3'd3;
  localparam logic [2:0] S_MAC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;
  localparam logic [2:0] S_END  = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           k_r, k_nxt;
  logic                 lane_r, lane_nxt;
  logic [FRAC_BITS-1:0] t_r, t_nxt;
  logic [FRAC_BITS-1:0] pos_r, pos_nxt;
  logic [1:0]           seen_r, seen_nxt;

  coord_t win_x_r [3];
  coord_t win_y_r [3];
  coord_t px_r, py_r;
  logic   last_r;
  logic [FRAC_BITS-1:0] tt_r;
  wgt_t   w_r [4];
  vout_t  vx_r;

  logic     win_clr, win_shift;
  coord_t   shift_x, shift_y;
  logic     take_in, wgt_load, vx_load;
  mac_ctl_t mac_ctl;
  mul_op_t  mac_a, mac_b;
  acc_t     acc;
  coord_t   cur_p;

  logic [FRAC_BITS:0]   t_sum;
  logic [FRAC_BITS-1:0] acc_mid;
  wgt_t                 tt_s, ttt_s, u_s;
  wgt_t                 w1, w2, w3, w4;

  crs_mac u_mac (
    .clk   (clk),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  // floor(product / 2^FRAC_BITS) of a square or cube step
  assign acc_mid = acc[2*FRAC_BITS-1:FRAC_BITS];
  assign t_sum   = {1'b0, t_r} + step_i;

  assign tt_s  = signed'(WGT_W'(tt_r));
  assign ttt_s = signed'(WGT_W'(acc_mid));
  assign u_s   = signed'(WGT_W'(t_r));
  assign w1 = (tt_s <<< 1) - ttt_s - u_s;
  assign w2 = (ttt_s <<< 1) + ttt_s - (tt_s <<< 2) - tt_s + wgt_t'(2 * ONE_SEG);
  assign w3 = (tt_s <<< 2) + u_s - (ttt_s <<< 1) - ttt_s;
  assign w4 = ttt_s - tt_s;

  always_comb begin
    unique case (k_r)
      2'd0: cur_p = lane_r ? win_y_r[0] : win_x_r[0];
      2'd1: cur_p = lane_r ? win_y_r[1] : win_x_r[1];
      2'd2: cur_p = lane_r ? win_y_r[2] : win_x_r[2];
      2'd3: cur_p = lane_r ? py_r : px_r;
      default: cur_p = '0;
    endcase
  end

  assign in_ready_o = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    lane_nxt  = lane_r;
    t_nxt     = t_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    win_clr   = 1'b0;
    win_shift = 1'b0;
    shift_x   = px_r;
    shift_y   = py_r;
    take_in   = 1'b0;
    wgt_load  = 1'b0;
    vx_load   = 1'b0;
    mac_ctl   = '0;
    mac_a     = '0;
    mac_b     = '0;
    vtx_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid_i) begin
          if (seen_r == 2'd3) begin
            take_in   = 1'b1;
            t_nxt     = pos_r;
            state_nxt = S_SQ;
          end else if (last_i) begin
            // short curve: nothing to draw
            win_clr  = 1'b1;
            seen_nxt = '0;
            pos_nxt  = '0;
          end else begin
            win_shift = 1'b1;
            shift_x   = px_i;
            shift_y   = py_i;
            seen_nxt  = seen_r + 2'd1;
          end
        end
      end
      S_SQ: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1};
        mac_a     = signed'(MUL_W'(t_r));
        mac_b     = signed'(MUL_W'(t_r));
        state_nxt = S_CUBE;
      end
      S_CUBE: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1};
        mac_a     = signed'(MUL_W'(acc_mid));
        mac_b     = signed'(MUL_W'(t_r));
        state_nxt = S_WGT;
      end
      S_WGT: begin
        wgt_load  = 1'b1;
        k_nxt     = '0;
        lane_nxt  = 1'b0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        mac_ctl = '{en: 1'b1, clr: (k_r == 2'd0)};
        mac_a   = signed'(MUL_W'(cur_p));
        mac_b   = MUL_W'(w_r[k_r]);
        k_nxt   = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = lane_r ? S_EMIT : S_FIN;
        end
      end
      S_FIN: begin
        vx_load   = 1'b1;
        lane_nxt  = 1'b1;
        state_nxt = S_MAC;
      end
      S_EMIT: begin
        if (slot_free_i) begin
          vtx_o = '{load: 1'b1, x: vx_r, y: scale_sat(acc), last: 1'b0};
          if (t_sum[FRAC_BITS]) begin
            // carry the leftover parameter into the next segment
            pos_nxt = t_sum[FRAC_BITS-1:0];
            if (last_r) begin
              state_nxt = S_END;
            end else begin
              win_shift = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            t_nxt     = t_sum[FRAC_BITS-1:0];
            state_nxt = S_SQ;
          end
        end
      end
      S_END: begin
        if (slot_free_i) begin
          vtx_o = '{load: 1'b1, x: signed'(OUT_W'(win_x_r[2])),
                    y: signed'(OUT_W'(win_y_r[2])), last: 1'b1};
          win_clr   = 1'b1;
          seen_nxt  = '0;
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      lane_r  <= 1'b0;
      t_r     <= '0;
      pos_r   <= '0;
      seen_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        win_x_r[i] <= '0;
        win_y_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      lane_r  <= lane_nxt;
      t_r     <= t_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
      if (win_clr) begin
        for (int i = 0; i < 3; i++) begin
          win_x_r[i] <= '0;
          win_y_r[i] <= '0;
        end
      end else if (win_shift) begin
        win_x_r[0] <= win_x_r[1];
        win_x_r[1] <= win_x_r[2];
        win_x_r[2] <= shift_x;
        win_y_r[0] <= win_y_r[1];
        win_y_r[1] <= win_y_r[2];
        win_y_r[2] <= shift_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      px_r   <= px_i;
      py_r   <= py_i;
      last_r <= last_i;
    end
    if (state_r == S_CUBE) begin
      tt_r <= acc_mid;
    end
    if (wgt_load) begin
      w_r[0] <= w1;
      w_r[1] <= w2;
      w_r[2] <= w3;
      w_r[3] <= w4;
    end
    if (vx_load) begin
      vx_r <= scale_sat(acc);
    end
  end

endmodule

`default_nettype wire

### sv/catmull_rom_curve_sampler.sv
// top level of the uniform catmull-rom curve sampler: step register,
// output register and the sequencer; depends on crs_pkg, crs_seq, crs_mac
`default_nettype none

// Takes 2D control points as stream requests and draws each uniform
// catmull-rom segment between the middle two of the last four points as
// polyline vertices, stepping a Q0.12 parameter by the configured step and
// carrying the leftover fraction into the next segment. A point flagged by
// in_tlast also emits the segment end point with out_tlast set and starts a
// new curve; curves of fewer than four points draw nothing. One multiplier
// is shared by all products, so each vertex is worked out in steps (square,
// cube, weights, four products per axis, x rounding, hand-off), and a point
// draws n vertices, plus the end point when flagged, where n is the number of
// samples falling in its segment (at most 63); a hand-off waits while the
// previous vertex is still stalled downstream. A point that completes no
// segment is taken without leaving the idle state. in_tready is low while a
// point is being worked on; the output register lets the next vertex be
// computed while the previous one waits downstream. cfg_data sets the step
// (Q0.12, clamped to 66..4096) and must only be written while the block is idle.
module catmull_rom_curve_sampler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [crs_pkg::IN_DATA_W-1:0]  in_tdata,   // point_x, point_y
  input  wire logic                           in_tlast,   // end_of_curve
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [crs_pkg::OUT_DATA_W-1:0]      out_tdata,  // vertex_x, vertex_y, zero pad
  output logic                                out_tlast,  // last_vertex
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [crs_pkg::STEP_W-1:0]     cfg_data    // step_size
);
  import crs_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_eff;
  logic              out_valid_r, out_valid_nxt;
  vout_t             out_x_r, out_y_r;
  logic              out_last_r;
  logic              slot_free;
  vtx_t              vtx;

  assign cfg_ready = 1'b1;

  always_comb begin
    priority if (step_r < STEP_W'(STEP_MIN)) begin
      step_eff = STEP_W'(STEP_MIN);
    end else if (step_r > STEP_W'(ONE_SEG)) begin
      step_eff = STEP_W'(ONE_SEG);
    end else begin
      step_eff = step_r;
    end
  end

  crs_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .px_i        (in_tdata[COORD_BITS-1:0]),
    .py_i        (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .last_i      (in_tlast),
    .step_i      (step_eff),
    .slot_free_i (slot_free),
    .vtx_o       (vtx)
  );

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (vtx.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_W'(STEP_RESET);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vtx.load) begin
      out_x_r    <= vtx.x;
      out_y_r    <= vtx.y;
      out_last_r <= vtx.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_y_r, out_x_r});
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### sv/crs_checker.sv
// port-level checks of the curve sampler, bound to the top level
// depends on crs_pkg for the port widths
`default_nettype none

module crs_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic [crs_pkg::IN_DATA_W-1:0] in_tdata,
  input wire logic                          in_tlast,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [crs_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tlast,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready,
  input wire logic [crs_pkg::STEP_W-1:0]    cfg_data
);
  import crs_pkg::*;

  // no vertex is pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("vertex pending after reset");

  // a stalled vertex request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled vertex changed");

  // saturation keeps both coordinates at or above the lower bound
  a_sat_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[OUT_W-1] && !out_tdata[OUT_W-2]) &&
                   !(out_tdata[2*OUT_W-1] && !out_tdata[2*OUT_W-2]))
    else $error("vertex below output range");

  // the curve end point is a control point, so it is never negative or wide
  a_end_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[OUT_W-1:COORD_BITS] == '0 &&
                                out_tdata[2*OUT_W-1:OUT_W+COORD_BITS] == '0)
    else $error("end point outside control point range");

endmodule

bind catmull_rom_curve_sampler crs_checker u_crs_checker (.*);

`default_nettype wire
